[hdl/tspes_pkg.sv]
// ----------------------------------------------------------------------------
// tspes_pkg
// shared types, codes and constants of the transport stream pes reassembler
// ----------------------------------------------------------------------------
package tspes_pkg;

  localparam int unsigned PktLen       = 188;
  localparam logic [7:0]  SyncByte     = 8'h47;
  localparam logic [7:0]  PidHiMask    = 8'h1F;
  localparam logic [7:0]  CcMask       = 8'h0F;
  localparam logic [7:0]  ErrMask      = 8'h80;
  localparam logic [7:0]  PcrFlagMask  = 8'h10;
  localparam logic [7:0]  OpcrFlagMask = 8'h08;
  localparam logic [7:0]  MaxAdaptLen  = 8'd182;
  localparam logic [7:0]  LastPos      = 8'(PktLen - 1);
  localparam logic [16:0] CountMax     = 17'h1FFFF;
  localparam int unsigned OutDataW     = 96;

  // internal per-packet verdict
  typedef enum logic [2:0] {
    V_LOST    = 3'd0,
    V_STARTED = 3'd1,
    V_CONT    = 3'd2,
    V_FIN     = 3'd3,
    V_OTHER   = 3'd4,
    V_DUP     = 3'd5,
    V_UNDEC   = 3'd7
  } verdict_e;

  // reported packet status
  typedef enum logic [2:0] {
    ST_LOST     = 3'd0,
    ST_STARTED  = 3'd1,
    ST_CONTINUE = 3'd2,
    ST_FINISHED = 3'd3,
    ST_OTHER    = 3'd4
  } status_e;

  // one result word (pcr_value is filled in at the output register)
  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        packet_done;
    status_e     packet_status;
    logic [12:0] packet_pid;
    logic [3:0]  packet_cc;
    logic [1:0]  adapt_control;
    logic        unit_start;
    logic        error_flag;
    logic        pcr_valid;
    logic [15:0] pes_length;
  } result_t;

endpackage

[hdl/tspes_in_stage.sv]
// ----------------------------------------------------------------------------
// tspes_in_stage
// input register for one stream word
// ----------------------------------------------------------------------------
module tspes_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // data_byte
  input  logic       s_axis_tuser,   // first_byte
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] data_byte_o,
  output logic       first_byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       first_q;

  assign s_axis_tready = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      byte_q  <= s_axis_tdata;
      first_q <= s_axis_tuser;
    end
  end

  assign valid_o      = valid_q;
  assign data_byte_o  = byte_q;
  assign first_byte_o = first_q;

endmodule

[hdl/tspes_pcr.sv]
// ----------------------------------------------------------------------------
// tspes_pcr
// registered pcr conversion: base * 300 + extension
// ----------------------------------------------------------------------------
module tspes_pcr (
  input  logic        clk_i,
  input  logic [47:0] pcr_shift_i,
  output logic [41:0] pcr_value_o
);

  logic [41:0] base;
  logic [41:0] ext;
  logic [41:0] pcr_d;
  logic [41:0] pcr_q;

  assign base = {9'd0, pcr_shift_i[47:15]};
  assign ext  = {33'd0, pcr_shift_i[8:0]};

  // 300 = 256 + 32 + 8 + 4
  assign pcr_d = (base << 8) + (base << 5) + (base << 3) + (base << 2) + ext;

  always_ff @(posedge clk_i) begin
    pcr_q <= pcr_d;
  end

  assign pcr_value_o = pcr_q;

endmodule

[hdl/tspes_core.sv]
// ----------------------------------------------------------------------------
// tspes_core
// per-byte packet decode, pid filter, continuity check and pes tracking
// ----------------------------------------------------------------------------
module tspes_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_wr_en_i,
  input  logic [12:0]       cfg_wr_data_i,
  input  logic              fire_i,
  input  logic [7:0]        data_byte_i,
  input  logic              first_byte_i,
  output tspes_pkg::result_t res_o,
  output logic [47:0]       pcr_shift_o
);
  import tspes_pkg::*;

  logic [12:0] target_pid_q;
  logic [7:0]  pos_q,       pos_d;
  logic [23:0] hdr_q,       hdr_d;
  logic [7:0]  alen_q,      alen_d;
  logic [47:0] pshift_q,    pshift_d;
  logic [3:0]  last_cc_q,   last_cc_d;
  logic        cc_known_q,  cc_known_d;
  logic        assembling_q, assembling_d;
  logic [15:0] pes_len_q,   pes_len_d;
  logic [16:0] pes_cnt_q,   pes_cnt_d;
  verdict_e    verdict_q,   verdict_d;
  logic        pflag_q,     pflag_d;

  logic [7:0]  pos;
  logic [7:0]  b1, b2, b3;
  logic [1:0]  afc;
  logic [12:0] pid;
  logic [3:0]  cc;
  logic        pusi;
  logic [8:0]  start;
  logic        pv;
  result_t     res;

  always_comb begin
    pos = first_byte_i ? 8'd0 : pos_q;
    if (pos > LastPos) begin
      pos = 8'd0;
    end

    hdr_d        = hdr_q;
    alen_d       = alen_q;
    pshift_d     = pshift_q;
    last_cc_d    = last_cc_q;
    cc_known_d   = cc_known_q;
    assembling_d = assembling_q;
    pes_len_d    = pes_len_q;
    pes_cnt_d    = pes_cnt_q;
    verdict_d    = verdict_q;
    pflag_d      = pflag_q;
    res          = '0;
    pv           = 1'b0;

    if (pos == 8'd0) begin
      verdict_d = (data_byte_i == SyncByte) ? V_UNDEC : V_LOST;
      hdr_d     = '0;
      alen_d    = '0;
      pshift_d  = '0;
      pflag_d   = 1'b0;
    end else if (pos <= 8'd3) begin
      hdr_d = {hdr_q[15:0], data_byte_i};
    end

    b1   = hdr_d[23:16];
    b2   = hdr_d[15:8];
    b3   = hdr_d[7:0];
    afc  = b3[5:4];
    pid  = {b1[4:0] & PidHiMask[4:0], b2};
    cc   = b3[3:0] & CcMask[3:0];
    pusi = b1[6];

    // no payload bit
    if (pos == 8'd3 && verdict_d == V_UNDEC && !afc[0]) begin
      verdict_d = V_LOST;
    end
    // adaptation length leaves no room for payload
    if (pos == 8'd4 && afc[1]) begin
      alen_d = data_byte_i;
      if (data_byte_i > MaxAdaptLen && verdict_d == V_UNDEC) begin
        verdict_d = V_LOST;
      end
    end
    if (pos == 8'd5 && afc[1] && alen_d != 8'd0 &&
        (data_byte_i & (PcrFlagMask | OpcrFlagMask)) != 8'd0) begin
      pflag_d = 1'b1;
    end
    if (pos >= 8'd6 && pos <= 8'd11) begin
      pshift_d = {pshift_q[39:0], data_byte_i};
    end

    // verdict on the first payload byte
    start = afc[1] ? ({1'b0, alen_d} + 9'd5) : 9'd4;
    if (pos >= 8'd4 && verdict_d == V_UNDEC && {1'b0, pos} == start) begin
      if (pid != target_pid_q) begin
        verdict_d = V_OTHER;
      end else if (cc_known_q && cc == last_cc_q) begin
        verdict_d = V_DUP;
      end else if (cc_known_q && cc != (last_cc_q + 4'd1)) begin
        assembling_d = 1'b0;
        cc_known_d   = 1'b0;
        verdict_d    = V_LOST;
      end else if (pusi) begin
        assembling_d = 1'b1;
        last_cc_d    = cc;
        cc_known_d   = 1'b1;
        pes_cnt_d    = '0;
        pes_len_d    = '0;
        verdict_d    = V_STARTED;
      end else if (assembling_q) begin
        last_cc_d  = cc;
        cc_known_d = 1'b1;
        verdict_d  = V_CONT;
      end else begin
        verdict_d = V_LOST;
      end
    end

    // payload forwarding, pes length picked from payload bytes 4 and 5
    if (verdict_d == V_STARTED || verdict_d == V_CONT) begin
      if (verdict_d == V_STARTED) begin
        if (pes_cnt_d == 17'd4) begin
          pes_len_d[15:8] = data_byte_i;
        end else if (pes_cnt_d == 17'd5) begin
          pes_len_d[7:0] = data_byte_i;
        end
      end
      if (pes_cnt_d < CountMax) begin
        pes_cnt_d = pes_cnt_d + 17'd1;
      end
      res.payload_valid = 1'b1;
      res.payload_byte  = data_byte_i;
    end

    if (pos == LastPos) begin
      pv = afc[1] && (alen_d >= 8'd7) && pflag_d;
      if (verdict_d == V_UNDEC) begin
        verdict_d = V_LOST;
      end
      if (verdict_d == V_CONT && pes_len_d != 16'd0 &&
          pes_cnt_d >= ({1'b0, pes_len_d} + 17'd6)) begin
        verdict_d    = V_FIN;
        assembling_d = 1'b0;
      end
      case (verdict_d)
        V_STARTED: res.packet_status = ST_STARTED;
        V_CONT:    res.packet_status = ST_CONTINUE;
        V_DUP:     res.packet_status = ST_CONTINUE;
        V_FIN:     res.packet_status = ST_FINISHED;
        V_OTHER:   res.packet_status = ST_OTHER;
        default:   res.packet_status = ST_LOST;
      endcase
      res.packet_done   = 1'b1;
      res.packet_pid    = pid;
      res.packet_cc     = cc;
      res.adapt_control = afc;
      res.unit_start    = pusi;
      res.error_flag    = (b1 & ErrMask) != 8'd0;
      res.pcr_valid     = pv;
      res.pes_length    = pes_len_d;
      pos_d             = 8'd0;
    end else begin
      pos_d = pos + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_pid_q <= '0;
    end else if (cfg_wr_en_i) begin
      target_pid_q <= cfg_wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      hdr_q        <= '0;
      alen_q       <= '0;
      pshift_q     <= '0;
      last_cc_q    <= '0;
      cc_known_q   <= 1'b0;
      assembling_q <= 1'b0;
      pes_len_q    <= '0;
      pes_cnt_q    <= '0;
      verdict_q    <= V_LOST;
      pflag_q      <= 1'b0;
    end else if (fire_i) begin
      pos_q        <= pos_d;
      hdr_q        <= hdr_d;
      alen_q       <= alen_d;
      pshift_q     <= pshift_d;
      last_cc_q    <= last_cc_d;
      cc_known_q   <= cc_known_d;
      assembling_q <= assembling_d;
      pes_len_q    <= pes_len_d;
      pes_cnt_q    <= pes_cnt_d;
      verdict_q    <= verdict_d;
      pflag_q      <= pflag_d;
    end
  end

  assign res_o       = res;
  assign pcr_shift_o = pshift_q;

endmodule

[hdl/tspes_out_stage.sv]
// ----------------------------------------------------------------------------
// tspes_out_stage
// result register and output word packing
// ----------------------------------------------------------------------------
module tspes_out_stage (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  tspes_pkg::result_t                  res_i,
  input  logic [41:0]                         pcr_value_i,
  output logic                                free_o,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // payload_byte, packet_status, packet_pid, packet_cc, adapt_control,
  // unit_start, error_flag, pcr_valid, pcr_value, pes_length, zero pad
  output logic [tspes_pkg::OutDataW-1:0]      m_axis_tdata,
  output logic                                m_axis_tuser,  // payload_valid
  output logic                                m_axis_tlast   // packet_done
);
  import tspes_pkg::*;

  logic        valid_q;
  result_t     res_q;
  logic [41:0] pcr_q;

  assign free_o = !valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      res_q <= res_i;
      pcr_q <= res_i.pcr_valid ? pcr_value_i : 42'd0;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tuser  = res_q.payload_valid;
  assign m_axis_tlast  = res_q.packet_done;
  assign m_axis_tdata  = {5'd0,
                          res_q.pes_length,
                          pcr_q,
                          res_q.pcr_valid,
                          res_q.error_flag,
                          res_q.unit_start,
                          res_q.adapt_control,
                          res_q.packet_cc,
                          res_q.packet_pid,
                          res_q.packet_status,
                          res_q.payload_byte};

endmodule

[hdl/ts_packet_pes_reassembler_unit.sv]
// ----------------------------------------------------------------------------
// ts_packet_pes_reassembler_unit
// transport stream packet parser and pes reassembler for one selected pid
// ----------------------------------------------------------------------------
// usage
// - slave stream takes one transport stream byte per word in tdata, tuser
//   marks byte 0 of a 188-byte packet (unmarked packets follow on by count)
// - master stream gives one result word per input word: tuser flags a
//   forwarded pes payload byte, tlast flags the last byte of a packet, and
//   then the packet fields in tdata are valid (zero otherwise)
// - target_pid is written through cfg_wr_en_i / cfg_wr_data_i while idle;
//   the user must keep to this, the block itself does not enforce it
// - an accepted word goes from the input register to the result register
// - throughput: one word per cycle unless the receiver stalls; the input
//   and result registers decouple the sides, per-byte decode is one short stage
// - pcr base*300+ext is computed in its own register from the captured
//   adaptation bytes, long settled by the time the packet's last byte comes
// - reset clears all packet and stream state; the next byte counts as byte 0
// - when the receiver stalls the result word holds and the input register
//   fills, then tready drops until the result is taken
// ----------------------------------------------------------------------------
module ts_packet_pes_reassembler_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_wr_en_i,
  input  logic [12:0]                    cfg_wr_data_i,   // target_pid
  // byte input
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,    // data_byte
  input  logic                           s_axis_tuser,    // first_byte
  // result output
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // payload_byte[7:0], packet_status[10:8], packet_pid[23:11],
  // packet_cc[27:24], adapt_control[29:28], unit_start[30], error_flag[31],
  // pcr_valid[32], pcr_value[74:33], pes_length[90:75], zero pad
  output logic [tspes_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                           m_axis_tuser,    // payload_valid
  output logic                           m_axis_tlast     // packet_done
);
  import tspes_pkg::*;

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_first;
  logic        out_free;
  logic        fire;
  result_t     res;
  logic [47:0] pcr_shift;
  logic [41:0] pcr_value;

  // a word moves from the input register to the result register
  assign fire = in_valid && out_free;

  tspes_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .take_i       (fire),
    .valid_o      (in_valid),
    .data_byte_o  (in_byte),
    .first_byte_o (in_first)
  );

  // header decode, verdict and pes state
  tspes_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wr_en_i  (cfg_wr_en_i),
    .cfg_wr_data_i(cfg_wr_data_i),
    .fire_i       (fire),
    .data_byte_i  (in_byte),
    .first_byte_i (in_first),
    .res_o        (res),
    .pcr_shift_o  (pcr_shift)
  );

  // program clock reference in 27 mhz ticks
  tspes_pcr u_pcr (
    .clk_i       (clk_i),
    .pcr_shift_i (pcr_shift),
    .pcr_value_o (pcr_value)
  );

  tspes_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (fire),
    .res_i        (res),
    .pcr_value_i  (pcr_value),
    .free_o       (out_free),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

[tb/sv/ts_packet_pes_reassembler_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ts_packet_pes_reassembler_unit_test
// self-checking bench for the transport stream pes reassembler: a clocked
// driver feeds packet bytes from a queue, a parser model in the bench works
// out the result word of every accepted byte, and a clocked monitor compares
// each result word as a whole; directed packets come first, then random
// packets under two more target pid settings
// ----------------------------------------------------------------------------
module ts_packet_pes_reassembler_unit_test;
  import tspes_pkg::*;

  localparam int unsigned CycleLimit = 3_000_000;
  localparam int          DrainLimit = 2000;
  localparam int          RandPkts   = 1;     // random packets per target setting

  // one stream byte as it goes over the slave side
  typedef struct packed {
    logic [7:0] data;
    logic       first;
  } ts_byte_t;

  // m_axis_tdata layout, lowest field last
  typedef struct packed {
    logic [4:0]  pad;
    logic [15:0] pes_length;
    logic [41:0] pcr_value;
    logic        pcr_valid;
    logic        error_flag;
    logic        unit_start;
    logic [1:0]  adapt_control;
    logic [3:0]  packet_cc;
    logic [12:0] packet_pid;
    logic [2:0]  packet_status;
    logic [7:0]  payload_byte;
  } ts_fields_t;

  typedef struct packed {
    logic       payload_valid;
    logic       packet_done;
    ts_fields_t f;
  } ts_result_t;

  // how one test packet is built
  typedef struct {
    logic [12:0] pid;
    logic [3:0]  cc;
    logic        pusi;
    logic        err;
    logic        bad_sync;
    logic        mark;
    logic [1:0]  afc;
    logic [7:0]  af_len;
    logic [7:0]  af_flags;
    logic [47:0] pcr_raw;
    logic [15:0] pes_len;
    int          keep;       // bytes actually sent, less than a packet abandons it
  } ts_pkt_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_wr_en_i   = 1'b0;
  logic [12:0]         cfg_wr_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;

  ts_packet_pes_reassembler_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  ts_byte_t    stream_q [$];   // bytes waiting to be driven
  ts_result_t  expect_q [$];   // predicted result words, oldest first
  int          mismatch_cnt = 0;
  int          rx_cnt       = 0;
  int unsigned cycle_cnt    = 0;
  int          tx_gap = 0, tx_calm = 0, rx_stall = 0, rx_calm = 0;
  ts_byte_t    tx_word;
  ts_result_t  rx_got, rx_want;

  // parser state of the bench, all zero after reset
  logic [12:0] pid_sel   = '0;
  logic [7:0]  pos_q     = '0;
  logic [23:0] hdr_q     = '0;
  logic [7:0]  af_len_q  = '0;
  logic [47:0] pcr_sr    = '0;
  logic [3:0]  cc_last   = '0;
  logic        cc_known  = 1'b0;
  logic        in_pes    = 1'b0;
  logic [15:0] pes_len_q = '0;
  logic [16:0] pes_cnt   = '0;
  logic        pcr_seen  = 1'b0;
  verdict_e    verdict   = V_LOST;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // parse one stream byte and give the result word it causes
  function automatic ts_result_t parse_ts_byte(input logic [7:0] b, input logic first);
    ts_result_t  r;
    logic [7:0]  p, b1, b2, b3;
    logic [1:0]  afc;
    logic [12:0] pid;
    logic [3:0]  cc;
    logic        pusi, pv;
    logic [8:0]  start;
    logic [41:0] base;
    status_e     st;
    r = '0;
    p = first ? 8'd0 : pos_q;
    if (p >= PktLen) p = '0;
    if (p == 0) begin
      verdict  = (b == SyncByte) ? V_UNDEC : V_LOST;
      hdr_q    = '0;
      af_len_q = '0;
      pcr_sr   = '0;
      pcr_seen = 1'b0;
    end else if (p <= 3) begin
      hdr_q = {hdr_q[15:0], b};
    end
    b1   = hdr_q[23:16];
    b2   = hdr_q[15:8];
    b3   = hdr_q[7:0];
    afc  = b3[5:4];
    pid  = {b1[4:0], b2};
    cc   = b3[3:0];
    pusi = b1[6];

    // no payload: payload bit clear, or adaptation field fills the packet
    if (p == 3 && verdict == V_UNDEC && !afc[0]) verdict = V_LOST;
    if (p == 4 && afc[1]) begin
      af_len_q = b;
      if (b > MaxAdaptLen && verdict == V_UNDEC) verdict = V_LOST;
    end
    if (p == 5 && afc[1] && af_len_q != 0 && (b & (PcrFlagMask | OpcrFlagMask)) != 0)
      pcr_seen = 1'b1;
    if (p >= 6 && p <= 11) pcr_sr = {pcr_sr[39:0], b};

    // verdict falls on the first payload byte
    start = afc[1] ? 9'd5 + af_len_q : 9'd4;
    if (p >= 4 && verdict == V_UNDEC && p == start) begin
      if (pid != pid_sel) begin
        verdict = V_OTHER;
      end else if (cc_known && cc == cc_last) begin
        verdict = V_DUP;
      end else if (cc_known && cc != cc_last + 4'd1) begin
        in_pes   = 1'b0;
        cc_known = 1'b0;
        verdict  = V_LOST;
      end else if (pusi) begin
        in_pes    = 1'b1;
        cc_last   = cc;
        cc_known  = 1'b1;
        pes_cnt   = '0;
        pes_len_q = '0;
        verdict   = V_STARTED;
      end else if (in_pes) begin
        cc_last  = cc;
        cc_known = 1'b1;
        verdict  = V_CONT;
      end else begin
        verdict = V_LOST;
      end
    end

    if (verdict == V_STARTED || verdict == V_CONT) begin
      // pes length sits in payload bytes 4 and 5 of the starting packet
      if (verdict == V_STARTED) begin
        if (pes_cnt == 17'd4) pes_len_q[15:8] = b;
        else if (pes_cnt == 17'd5) pes_len_q[7:0] = b;
      end
      if (pes_cnt != CountMax) pes_cnt++;
      r.payload_valid  = 1'b1;
      r.f.payload_byte = b;
    end

    if (p == LastPos) begin
      pv = afc[1] && (af_len_q >= 8'd7) && pcr_seen;
      if (verdict == V_UNDEC) verdict = V_LOST;
      if (verdict == V_CONT && pes_len_q != 0 && pes_cnt >= pes_len_q + 17'd6) begin
        verdict = V_FIN;
        in_pes  = 1'b0;
      end
      case (verdict)
        V_STARTED:    st = ST_STARTED;
        V_CONT, V_DUP: st = ST_CONTINUE;
        V_FIN:        st = ST_FINISHED;
        V_OTHER:      st = ST_OTHER;
        default:      st = ST_LOST;
      endcase
      r.packet_done     = 1'b1;
      r.f.packet_status = st;
      r.f.packet_pid    = pid;
      r.f.packet_cc     = cc;
      r.f.adapt_control = afc;
      r.f.unit_start    = pusi;
      r.f.error_flag    = b1[7];
      r.f.pcr_valid     = pv;
      if (pv) begin
        base            = 42'(pcr_sr[47:15]);
        r.f.pcr_value   = base * 42'd300 + 42'(pcr_sr[8:0]);
      end
      r.f.pes_length    = pes_len_q;
      pos_q = '0;
    end else begin
      pos_q = p + 8'd1;
    end
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [15:0] rand_pes_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 16'($urandom_range(0, 6));
    if (r < 75) return 16'($urandom_range(1, 500));
    if (r < 85) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic ts_pkt_t basic_pkt(input logic [12:0] pid, input logic [3:0] cc,
                                        input logic pusi, input logic [15:0] pes_len);
    ts_pkt_t d;
    d.pid      = pid;
    d.cc       = cc;
    d.pusi     = pusi;
    d.err      = 1'b0;
    d.bad_sync = 1'b0;
    d.mark     = 1'b1;
    d.afc      = 2'b01;
    d.af_len   = '0;
    d.af_flags = '0;
    d.pcr_raw  = 48'({$urandom, $urandom});
    d.pes_len  = pes_len;
    d.keep     = PktLen;
    return d;
  endfunction

  // lay out one 188-byte packet and queue its first keep bytes
  task automatic queue_packet(input ts_pkt_t d);
    logic [7:0] pkt [PktLen];
    logic [7:0] pes_hdr [6];
    int         k, at;
    ts_byte_t   w;
    for (k = 0; k < PktLen; k++) pkt[k] = 8'($urandom);
    pkt[0] = SyncByte;
    if (d.bad_sync) begin
      pkt[0] = 8'($urandom);
      if (pkt[0] == SyncByte) pkt[0] = ~SyncByte;
    end
    pkt[1] = {d.err, d.pusi, 1'($urandom), d.pid[12:8]};
    pkt[2] = d.pid[7:0];
    pkt[3] = {2'($urandom), d.afc, d.cc};
    at = 4;
    if (d.afc[1]) begin
      pkt[4] = d.af_len;
      pkt[5] = d.af_flags;
      for (k = 0; k < 6; k++) pkt[6 + k] = d.pcr_raw[47 - 8 * k -: 8];
      at = 5 + d.af_len;
    end
    // pes header start code, stream id and length
    pes_hdr = '{8'h00, 8'h00, 8'h01, 8'hE0, d.pes_len[15:8], d.pes_len[7:0]};
    if (d.pusi) begin
      for (k = 0; k < 6; k++) if (at + k < PktLen) pkt[at + k] = pes_hdr[k];
    end
    for (k = 0; k < d.keep; k++) begin
      w.data  = pkt[k];
      w.first = (k == 0) ? d.mark : 1'b0;
      stream_q.push_back(w);
    end
  endtask

  // random packet stream, mostly an in-order pes stream on the target pid
  task automatic random_packets(input logic [12:0] target, input int n);
    ts_pkt_t    d;
    logic [3:0] next_cc, prev_cc;
    int         i, r;
    next_cc = 4'($urandom);
    prev_cc = next_cc - 4'd1;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      d = basic_pkt(target, next_cc, $urandom_range(0, 3) == 0, rand_pes_len());
      if ($urandom_range(0, 3) == 0) begin
        d.afc      = 2'b11;
        d.af_len   = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 12))
                                                : 8'($urandom_range(0, 182));
        d.af_flags = 8'($urandom);
      end
      d.err  = $urandom_range(0, 9) == 0;
      d.mark = $urandom_range(0, 7) != 0;
      if (r < 62) begin
        prev_cc = next_cc;
        next_cc = next_cc + 4'd1;
      end else if (r < 70) begin
        d.cc = prev_cc;                               // repeated packet
      end else if (r < 76) begin
        d.cc    = next_cc + 4'($urandom_range(1, 14)); // continuity break
        prev_cc = d.cc;
        next_cc = d.cc + 4'd1;
      end else if (r < 86) begin
        d.pid = 13'($urandom);
        case ($urandom_range(0, 3))
          0:       d.pid = '0;
          1:       d.pid = '1;
          default: ;
        endcase
        if (d.pid == target) d.pid = ~target;
      end else if (r < 90) begin
        d.bad_sync = 1'b1;
      end else if (r < 94) begin
        case ($urandom_range(0, 2))
          0:       d.afc = 2'b00;
          1:       d.afc = 2'b10;
          default: begin
            d.afc    = 2'b11;
            d.af_len = 8'($urandom_range(183, 255));
          end
        endcase
      end else if (r < 97) begin
        d.keep  = $urandom_range(1, PktLen - 1);      // cut short by the next mark
        prev_cc = next_cc;
        next_cc = next_cc + 4'd1;
      end else begin
        d.pid      = $urandom_range(0, 1) ? target : 13'($urandom);
        d.cc       = 4'($urandom);
        d.pusi     = 1'($urandom);
        d.afc      = 2'($urandom);
        d.af_len   = 8'($urandom);
        d.af_flags = 8'($urandom);
      end
      queue_packet(d);
    end
  endtask

  // all bytes taken and all result words seen
  task automatic wait_drained();
    int n;
    n = 0;
    @(negedge clk_i);
    while (stream_q.size() != 0 || s_axis_tvalid) @(negedge clk_i);
    while (expect_q.size() != 0 && n < DrainLimit) begin
      @(negedge clk_i);
      n++;
    end
  endtask

  task automatic write_target(input logic [12:0] v);
    wait_drained();
    repeat (3) @(posedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= v;
    pid_sel = v;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // byte driver, one word per handshake
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expect_q.push_back(parse_ts_byte(s_axis_tdata, s_axis_tuser));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (stream_q.size() != 0) begin
          tx_word = stream_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= tx_word.data;
          s_axis_tuser  <= tx_word.first;
          if (tx_calm > 0) begin
            tx_calm--;
          end else begin
            tx_gap = idle_len();
            if ($urandom_range(0, 299) == 0) tx_calm = $urandom_range(100, 400);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        rx_got.payload_valid = m_axis_tuser;
        rx_got.packet_done   = m_axis_tlast;
        rx_got.f             = m_axis_tdata;
        if (expect_q.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("word %0d: no result expected, got valid=%b done=%b data=%h",
                     rx_cnt, rx_got.payload_valid, rx_got.packet_done, rx_got.f);
          mismatch_cnt++;
        end else begin
          rx_want = expect_q.pop_front();
          if (rx_got !== rx_want) begin
            if (mismatch_cnt < 10)
              $display("word %0d: expected valid=%b done=%b data=%h, got valid=%b done=%b data=%h",
                       rx_cnt, rx_want.payload_valid, rx_want.packet_done, rx_want.f,
                       rx_got.payload_valid, rx_got.packet_done, rx_got.f);
            mismatch_cnt++;
          end
        end
        rx_cnt++;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (rx_calm > 0) begin
          rx_calm--;
        end else begin
          rx_stall = idle_len();
          if ($urandom_range(0, 299) == 0) rx_calm = $urandom_range(100, 400);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    ts_pkt_t     d;
    logic [12:0] tgt [2];
    logic [12:0] t;
    int          ph;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed packets for one target pid, short ones are abandoned by the next mark
    t = 13'h0100;
    write_target(t);
    d = basic_pkt(t, 4'd0, 1'b1, 16'd10);             // pes start, largest pcr
    d.afc = 2'b11; d.af_len = 8'd7; d.af_flags = PcrFlagMask; d.pcr_raw = '1;
    queue_packet(d);
    queue_packet(basic_pkt(t, 4'd0, 1'b0, 16'd0));   // same cc again, dropped
    d = basic_pkt(t, 4'd1, 1'b0, 16'd0);             // continue reaches length + 6
    d.err = 1'b1;
    queue_packet(d);
    d = basic_pkt(t, 4'd2, 1'b0, 16'd0);             // continuation with no pes open
    d.keep = 12;
    queue_packet(d);
    d = basic_pkt(t, 4'd2, 1'b1, 16'h1234);          // start, length bytes taken
    d.keep = 16;
    queue_packet(d);
    d = basic_pkt(t, 4'd3, 1'b0, 16'd0);             // continuation forwards
    d.keep = 12;
    queue_packet(d);
    d = basic_pkt(t, 4'd7, 1'b0, 16'd0);             // cc jump
    d.keep = 8;
    queue_packet(d);
    d = basic_pkt(t, 4'd12, 1'b1, 16'hFFFF);         // unknown cc taken
    d.keep = 16;
    queue_packet(d);
    queue_packet(basic_pkt(~t, 4'd13, 1'b0, 16'd0)); // other pid
    d = basic_pkt(t, 4'd13, 1'b0, 16'd0);
    d.bad_sync = 1'b1;
    d.keep = 8;
    queue_packet(d);
    d = basic_pkt(t, 4'd13, 1'b0, 16'd0);            // adaptation only
    d.afc = 2'b10; d.af_len = 8'd183; d.keep = 8;
    queue_packet(d);
    d = basic_pkt(t, 4'd13, 1'b0, 16'd0);            // reserved control, no payload
    d.afc = 2'b00; d.keep = 8;
    queue_packet(d);
    d = basic_pkt(t, 4'd13, 1'b0, 16'd0);            // adaptation field too long
    d.afc = 2'b11; d.af_len = 8'd183; d.keep = 8;
    queue_packet(d);
    d = basic_pkt(t, 4'd13, 1'b0, 16'd0);            // continuation cut short
    d.keep = 20;
    queue_packet(d);
    d = basic_pkt(t, 4'd14, 1'b0, 16'd0);            // empty adaptation field
    d.afc = 2'b11; d.af_len = 8'd0; d.af_flags = 8'hFF; d.keep = 12;
    queue_packet(d);
    d = basic_pkt(t, 4'd15, 1'b0, 16'd0);            // single payload byte
    d.afc = 2'b11; d.af_len = 8'd182; d.af_flags = PcrFlagMask;
    queue_packet(d);
    d = basic_pkt(t, 4'd0, 1'b0, 16'd0);             // adaptation length 255
    d.afc = 2'b11; d.af_len = 8'd255; d.keep = 8;
    queue_packet(d);

    // random packets under the extreme targets
    tgt = '{13'h0000, 13'h1FFF};
    for (ph = 0; ph < 2; ph++) begin
      write_target(tgt[ph]);
      random_packets(tgt[ph], RandPkts);
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (expect_q.size() != 0) begin
      $display("%0d expected result words never arrived", expect_q.size());
      mismatch_cnt += expect_q.size();
    end
    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
hdl/tspes_pkg.sv
hdl/tspes_in_stage.sv
hdl/tspes_pcr.sv
hdl/tspes_core.sv
hdl/tspes_out_stage.sv
hdl/ts_packet_pes_reassembler_unit.sv
tb/sv/ts_packet_pes_reassembler_unit_test.sv
